/* hw/rtl/hcc_pkg.sv */
// Shared types, constants and per-level step functions for the Hilbert curve converter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package hcc_pkg;

  localparam int MaxOrder       = 16;
  localparam int CoordW         = 16;
  localparam int IndexW         = 32;
  localparam int OrderW         = 5;
  localparam int LevelW         = $clog2(MaxOrder);
  localparam int NumLevelStages = 4;
  localparam int LevelsPerStage = MaxOrder / NumLevelStages;
  localparam int StageW         = $clog2(NumLevelStages);

  localparam logic [OrderW-1:0] OrderReset   = OrderW'(MaxOrder);
  localparam logic [OrderW-1:0] MaxOrderCode = OrderW'(MaxOrder);

  // command codes
  localparam logic CmdIndexToXy = 1'b0;
  localparam logic CmdXyToIndex = 1'b1;

  // word holds the curve index (index to xy) or the growing distance (xy to index)
  typedef struct packed {
    logic              cmd;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [IndexW-1:0] word;
  } hcc_item_t;

  // quadrant reflect and transpose within a side of 2^lvl
  function automatic hcc_item_t hcc_turn(hcc_item_t it, logic rx, logic ry,
                                         logic [LevelW-1:0] lvl);
    logic [CoordW-1:0] mask;
    logic [CoordW-1:0] tx;
    hcc_item_t         r;
    r    = it;
    mask = (CoordW'(1) << lvl) - CoordW'(1);
    if (!ry) begin
      if (rx) begin
        r.x = ~r.x & mask;
        r.y = ~r.y & mask;
      end
      tx  = r.x;
      r.x = r.y;
      r.y = tx;
    end
    return r;
  endfunction

  // one level of index to xy, finest first; x and y hold only bits below lvl
  function automatic hcc_item_t hcc_d2xy_step(hcc_item_t it, logic [LevelW-1:0] lvl);
    logic      rx;
    logic      ry;
    hcc_item_t r;
    rx       = it.word[{lvl, 1'b1}];
    ry       = it.word[{lvl, 1'b0}] ^ rx;
    r        = hcc_turn(it, rx, ry, lvl);
    r.x[lvl] = rx;
    r.y[lvl] = ry;
    return r;
  endfunction

  // one level of xy to index, coarsest first
  function automatic hcc_item_t hcc_xy2d_step(hcc_item_t it, logic [LevelW-1:0] lvl);
    logic      rx;
    logic      ry;
    hcc_item_t r;
    rx                   = it.x[lvl];
    ry                   = it.y[lvl];
    r                    = it;
    r.word[{lvl, 1'b1}]  = rx;
    r.word[{lvl, 1'b0}]  = rx ^ ry;
    r.x[lvl]             = 1'b0;
    r.y[lvl]             = 1'b0;
    r                    = hcc_turn(r, rx, ry, lvl);
    return r;
  endfunction

endpackage

/* hw/rtl/hcc_entry.sv */
// Entry stage: registers an input item and sets up the working coordinates and word.
// Depends on hcc_pkg.
`timescale 1ns / 1ps

module hcc_entry (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  logic                       command,
  input  logic [hcc_pkg::IndexW-1:0] curve_index,
  input  logic [hcc_pkg::CoordW-1:0] x_in,
  input  logic [hcc_pkg::CoordW-1:0] y_in,
  input  logic [hcc_pkg::OrderW-1:0] order_eff,
  output logic                       dn_valid,
  input  logic                       dn_stall,
  output hcc_pkg::hcc_item_t         dn_item
);
  import hcc_pkg::*;

  logic              vld;
  hcc_item_t         item;
  hcc_item_t         item_next;
  logic [CoordW-1:0] coord_mask;

  // order is at most CoordW, so one spare bit holds 2^order
  assign coord_mask = CoordW'((( CoordW+1)'(1) << order_eff) - (CoordW+1)'(1));

  always_comb begin
    item_next.cmd = command;
    if (command == CmdXyToIndex) begin
      item_next.x    = x_in & coord_mask;
      item_next.y    = y_in & coord_mask;
      item_next.word = '0;
    end else begin
      item_next.x    = '0;
      item_next.y    = '0;
      item_next.word = curve_index;
    end
  end

  assign up_stall = vld && dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!up_stall) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      item <= item_next;
    end
  end

  assign dn_valid = vld;
  assign dn_item  = item;

endmodule

/* hw/rtl/hcc_level.sv */
// Level stage: applies LevelsPerStage curve levels in either direction, then registers.
// Depends on hcc_pkg; stage_num is tied to a constant at the top level.
`timescale 1ns / 1ps

module hcc_level (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hcc_pkg::StageW-1:0] stage_num,
  input  logic [hcc_pkg::OrderW-1:0] order_eff,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  hcc_pkg::hcc_item_t         up_item,
  output logic                       dn_valid,
  input  logic                       dn_stall,
  output hcc_pkg::hcc_item_t         dn_item
);
  import hcc_pkg::*;

  logic      vld;
  hcc_item_t item;
  hcc_item_t item_next;

  // index to xy climbs from level 0; xy to index descends from the top level
  always_comb begin
    logic [LevelW-1:0] lvl_fwd;
    logic [LevelW-1:0] lvl_rev;
    item_next = up_item;
    for (int j = 0; j < LevelsPerStage; j++) begin
      lvl_fwd = LevelW'(int'(stage_num) * LevelsPerStage + j);
      lvl_rev = LevelW'(MaxOrder - 1 - (int'(stage_num) * LevelsPerStage + j));
      if (item_next.cmd == CmdXyToIndex) begin
        if (OrderW'(lvl_rev) < order_eff) begin
          item_next = hcc_xy2d_step(item_next, lvl_rev);
        end
      end else begin
        if (OrderW'(lvl_fwd) < order_eff) begin
          item_next = hcc_d2xy_step(item_next, lvl_fwd);
        end
      end
    end
  end

  assign up_stall = vld && dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!up_stall) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      item <= item_next;
    end
  end

  assign dn_valid = vld;
  assign dn_item  = item;

endmodule

/* hw/rtl/hcc_out.sv */
// Output stage: selects the result fields by command and holds them for the sink.
// Depends on hcc_pkg.
`timescale 1ns / 1ps

module hcc_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  hcc_pkg::hcc_item_t         up_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hcc_pkg::CoordW-1:0] x_out,
  output logic [hcc_pkg::CoordW-1:0] y_out,
  output logic [hcc_pkg::IndexW-1:0] index_out
);
  import hcc_pkg::*;

  logic              vld;
  logic [CoordW-1:0] x;
  logic [CoordW-1:0] y;
  logic [IndexW-1:0] idx;

  assign up_stall = vld && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!up_stall) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      if (up_item.cmd == CmdXyToIndex) begin
        x   <= '0;
        y   <= '0;
        idx <= up_item.word;
      end else begin
        x   <= up_item.x;
        y   <= up_item.y;
        idx <= '0;
      end
    end
  end

  assign out_valid = vld;
  assign x_out     = x;
  assign y_out     = y;
  assign index_out = idx;

endmodule

/* hw/rtl/hilbert_curve_converter_core.sv */
// Top level of the Hilbert curve converter: order register and the six-stage pipeline.
// Depends on hcc_pkg, hcc_entry, hcc_level and hcc_out.
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// -------   ------------------   ---------------------------------------
// in        in_valid / in_stall  command, curve_index, x_in, y_in
// out       out_valid/out_stall  x_out, y_out, index_out
// cfg       cfg_valid/cfg_ready  cfg_data (curve_order)
//
// One item per cycle sustained while out_stall stays low; each item passes the
// entry stage, four level stages of four levels each, and the output register.
// Synchronous active-high reset empties the pipeline and sets order to 16.
// Each stage stalls only when it is full and the stage after it stalls, so
// bubbles close up and in_stall rises only with every stage full.
// cfg_ready is always high; write the order only while no item is in flight.

module hilbert_curve_converter_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [hcc_pkg::IndexW-1:0] curve_index,
  input  logic [hcc_pkg::CoordW-1:0] x_in,
  input  logic [hcc_pkg::CoordW-1:0] y_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hcc_pkg::CoordW-1:0] x_out,
  output logic [hcc_pkg::CoordW-1:0] y_out,
  output logic [hcc_pkg::IndexW-1:0] index_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hcc_pkg::OrderW-1:0] cfg_data
);
  import hcc_pkg::*;

  logic [OrderW-1:0] curve_order;
  logic [OrderW-1:0] order_eff;

  // stage k feeds stage k+1; index 0 is the entry stage
  logic      stg_valid [NumLevelStages+1];
  logic      stg_stall [NumLevelStages+1];
  hcc_item_t stg_item  [NumLevelStages+1];

  // order register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= OrderReset;
    end else if (cfg_valid && cfg_ready) begin
      curve_order <= cfg_data;
    end
  end

  // orders beyond the deepest supported level saturate
  assign order_eff = (curve_order > MaxOrderCode) ? MaxOrderCode : curve_order;

  hcc_entry u_entry (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_stall   (in_stall),
    .command    (command),
    .curve_index(curve_index),
    .x_in       (x_in),
    .y_in       (y_in),
    .order_eff  (order_eff),
    .dn_valid   (stg_valid[0]),
    .dn_stall   (stg_stall[0]),
    .dn_item    (stg_item[0])
  );

  for (genvar k = 0; k < NumLevelStages; k++) begin : g_level
    hcc_level u_level (
      .clk      (clk),
      .rst      (rst),
      .stage_num(StageW'(k)),
      .order_eff(order_eff),
      .up_valid (stg_valid[k]),
      .up_stall (stg_stall[k]),
      .up_item  (stg_item[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_stall (stg_stall[k+1]),
      .dn_item  (stg_item[k+1])
    );
  end

  hcc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stg_valid[NumLevelStages]),
    .up_stall (stg_stall[NumLevelStages]),
    .up_item  (stg_item[NumLevelStages]),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .x_out    (x_out),
    .y_out    (y_out),
    .index_out(index_out)
  );

`ifndef NO_ASSERTIONS
  // a result carries either coordinates or a distance, never both
  a_one_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (index_out == '0) || (x_out == '0 && y_out == '0))
    else $error("result carries both coordinates and a distance");

  // input backs up only when every stage holds an item and the sink stalls
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && stg_valid[0] && stg_valid[1] &&
                  stg_valid[2] && stg_valid[3] && stg_valid[4]))
    else $error("input stalled with a bubble in the pipeline");

  // reset leaves no result behind
  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !stg_valid[0])
    else $error("pipeline not empty after reset");
`endif

endmodule
